>>> hdl/framed_packet_relay_toggler_macros.svh
// Assertion macros used by the framed packet relay toggler port checker.
`ifndef FRAMED_PACKET_RELAY_TOGGLER_MACROS_SVH
`define FRAMED_PACKET_RELAY_TOGGLER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FPRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define FPRT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/fprt_pkg.sv
// Package with the types, codes and reset values of the framed packet relay toggler.
package fprt_pkg;

    // Register map indexes (byte address is four times the index).
    localparam logic [2:0] REG_FIRST_START  = 3'd0;
    localparam logic [2:0] REG_SECOND_START = 3'd1;
    localparam logic [2:0] REG_TRAILER      = 3'd2;
    localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd3;
    localparam logic [2:0] REG_LEFT_TYPE    = 3'd4;
    localparam logic [2:0] REG_RIGHT_TYPE   = 3'd5;

    // Register reset values.
    localparam logic [7:0] RST_FIRST_START  = 8'h55;
    localparam logic [7:0] RST_SECOND_START = 8'hAA;
    localparam logic [7:0] RST_TRAILER      = 8'h45;
    localparam logic [7:0] RST_MAX_PAYLOAD  = 8'd23;
    localparam logic [7:0] RST_LEFT_TYPE    = 8'd2;
    localparam logic [7:0] RST_RIGHT_TYPE   = 8'd3;

    // Bit zero of the second start byte is ignored in the header check.
    localparam logic [7:0] SECOND_START_MASK = 8'hFE;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_START2  = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_LENGTH  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_TRAILER = 6'b100000
    } t_phase;

    // Configuration registers as seen by the parser.
    typedef struct packed {
        logic [7:0] first_start;
        logic [7:0] second_start;
        logic [7:0] trailer;
        logic [7:0] max_payload;
        logic [7:0] left_type;
        logic [7:0] right_type;
    } t_cfg;

    // Result of one received byte.
    typedef struct packed {
        logic relay_one;
        logic relay_two;
        logic accepted;
        logic dropped;
    } t_result;

endpackage

>>> hdl/fprt_parser.sv
// Frame parser: phase register, held header fields, payload counter and relay state.
module fprt_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  fprt_pkg::t_cfg   i_cfg,
    output fprt_pkg::t_result o_result
);

    fprt_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_held_first, n_held_first;
    logic [7:0] r_held_second, n_held_second;
    logic [7:0] r_held_type, n_held_type;
    logic [7:0] r_held_length, n_held_length;
    logic [7:0] r_count, n_count;
    logic       r_relay_one, n_relay_one;
    logic       r_relay_two, n_relay_two;
    logic       accepted;
    logic       dropped;

    // Next state and result for the byte in the input register.
    always_comb begin
        n_phase       = r_phase;
        n_held_first  = r_held_first;
        n_held_second = r_held_second;
        n_held_type   = r_held_type;
        n_held_length = r_held_length;
        n_count       = r_count;
        n_relay_one   = r_relay_one;
        n_relay_two   = r_relay_two;
        accepted      = 1'b0;
        dropped       = 1'b0;
        unique case (r_phase)
            fprt_pkg::PH_IDLE: begin
                if (i_byte == i_cfg.first_start) begin
                    n_held_first = i_byte;
                    n_phase      = fprt_pkg::PH_START2;
                end
            end
            fprt_pkg::PH_START2: begin
                n_held_second = i_byte;
                n_phase       = fprt_pkg::PH_TYPE;
            end
            fprt_pkg::PH_TYPE: begin
                n_held_type = i_byte;
                n_phase     = fprt_pkg::PH_LENGTH;
            end
            fprt_pkg::PH_LENGTH: begin
                n_held_length = i_byte;
                if (r_held_first != i_cfg.first_start ||
                    (r_held_second & fprt_pkg::SECOND_START_MASK) != i_cfg.second_start ||
                    i_byte > i_cfg.max_payload) begin
                    dropped = 1'b1;
                    n_phase = fprt_pkg::PH_IDLE;
                end else if (i_byte == 8'd0) begin
                    n_phase = fprt_pkg::PH_TRAILER;
                end else begin
                    n_count = 8'd0;
                    n_phase = fprt_pkg::PH_PAYLOAD;
                end
            end
            fprt_pkg::PH_PAYLOAD: begin
                n_count = r_count + 8'd1;
                if (n_count == r_held_length) begin
                    n_phase = fprt_pkg::PH_TRAILER;
                end
            end
            fprt_pkg::PH_TRAILER: begin
                if (i_byte == i_cfg.trailer) begin
                    accepted = 1'b1;
                    // The left code wins when both codes are equal.
                    if (r_held_type == i_cfg.left_type) begin
                        n_relay_one = ~r_relay_one;
                    end else if (r_held_type == i_cfg.right_type) begin
                        n_relay_two = ~r_relay_two;
                    end
                end else begin
                    dropped = 1'b1;
                end
                n_phase = fprt_pkg::PH_IDLE;
            end
            default: begin
                n_phase = fprt_pkg::PH_IDLE;
            end
        endcase
    end

    assign o_result = '{relay_one: n_relay_one, relay_two: n_relay_two,
                        accepted: accepted, dropped: dropped};

    // Parser state advances once per byte that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= fprt_pkg::PH_IDLE;
            r_held_first  <= 8'd0;
            r_held_second <= 8'd0;
            r_held_type   <= 8'd0;
            r_held_length <= 8'd0;
            r_count       <= 8'd0;
            r_relay_one   <= 1'b0;
            r_relay_two   <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_held_first  <= n_held_first;
            r_held_second <= n_held_second;
            r_held_type   <= n_held_type;
            r_held_length <= n_held_length;
            r_count       <= n_count;
            r_relay_one   <= n_relay_one;
            r_relay_two   <= n_relay_two;
        end
    end

endmodule

>>> hdl/framed_packet_relay_toggler.sv
// Top level of the framed packet relay toggler: register file, input and result registers.
//
//   Channel   Direction  Handshake         Payload
//   input     in         i_valid/o_stall   i_rx_byte
//   result    out        o_valid/i_stall   o_relay_one_level, o_relay_two_level,
//                                          o_frame_accepted, o_frame_dropped
//   config    in         APB write/read    paddr, pwdata, prdata
//
// Every byte gives exactly one result word. One byte per cycle is sustained while the
// result side does not stall: input register, parser logic, result register.
// Synchronous active-low reset returns the parser to idle, turns both relays off
// and loads the register reset values.
// A stall on the result side holds the result register; the input register keeps
// taking words until both registers are full.
module framed_packet_relay_toggler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_relay_one_level,
    output logic        o_relay_two_level,
    output logic        o_frame_accepted,
    output logic        o_frame_dropped,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fprt_pkg::t_cfg    r_cfg;
    fprt_pkg::t_result step_result;
    logic [2:0]        reg_index;
    logic              cfg_write;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    fprt_pkg::t_result r_out;
    logic              out_free;
    logic              in_free;
    logic              step;

    // Configuration register file.
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_start  <= fprt_pkg::RST_FIRST_START;
            r_cfg.second_start <= fprt_pkg::RST_SECOND_START;
            r_cfg.trailer      <= fprt_pkg::RST_TRAILER;
            r_cfg.max_payload  <= fprt_pkg::RST_MAX_PAYLOAD;
            r_cfg.left_type    <= fprt_pkg::RST_LEFT_TYPE;
            r_cfg.right_type   <= fprt_pkg::RST_RIGHT_TYPE;
        end else if (cfg_write) begin
            unique case (reg_index)
                fprt_pkg::REG_FIRST_START:  r_cfg.first_start  <= pwdata[7:0];
                fprt_pkg::REG_SECOND_START: r_cfg.second_start <= pwdata[7:0];
                fprt_pkg::REG_TRAILER:      r_cfg.trailer      <= pwdata[7:0];
                fprt_pkg::REG_MAX_PAYLOAD:  r_cfg.max_payload  <= pwdata[7:0];
                fprt_pkg::REG_LEFT_TYPE:    r_cfg.left_type    <= pwdata[7:0];
                fprt_pkg::REG_RIGHT_TYPE:   r_cfg.right_type   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_index)
            fprt_pkg::REG_FIRST_START:  prdata = {24'd0, r_cfg.first_start};
            fprt_pkg::REG_SECOND_START: prdata = {24'd0, r_cfg.second_start};
            fprt_pkg::REG_TRAILER:      prdata = {24'd0, r_cfg.trailer};
            fprt_pkg::REG_MAX_PAYLOAD:  prdata = {24'd0, r_cfg.max_payload};
            fprt_pkg::REG_LEFT_TYPE:    prdata = {24'd0, r_cfg.left_type};
            fprt_pkg::REG_RIGHT_TYPE:   prdata = {24'd0, r_cfg.right_type};
            default:                    prdata = 32'd0;
        endcase
    end

    // Flow control: each register takes a word when it is empty or is being emptied.
    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign in_free  = !r_in_valid || out_free;
    assign o_stall  = !in_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    fprt_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Result register; the relay levels start off so they match the parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= step;
            end
            if (step) begin
                r_out <= step_result;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_relay_one_level = r_out.relay_one;
    assign o_relay_two_level = r_out.relay_two;
    assign o_frame_accepted  = r_out.accepted;
    assign o_frame_dropped   = r_out.dropped;

endmodule

>>> hdl/fprt_port_check.sv
// Port-level checks of the framed packet relay toggler and their binding.
`include "framed_packet_relay_toggler_macros.svh"

module fprt_port_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_relay_one_level,
    input logic o_relay_two_level,
    input logic o_frame_accepted,
    input logic o_frame_dropped,
    input logic pready
);

    // A word never reports a frame as both accepted and dropped.
    `FPRT_ASSERT(a_flags_exclusive, i_clk, i_rst_n, o_valid |-> !(o_frame_accepted && o_frame_dropped), "accepted and dropped both set")

    // The level of relay one changes only with a word that accepts a frame.
    `FPRT_ASSERT(a_relay_one_on_accept, i_clk, i_rst_n, ($past(i_rst_n) && (o_relay_one_level != $past(o_relay_one_level))) |-> (o_valid && o_frame_accepted), "relay one changed without an accepted frame")

    // One accepted frame never toggles both relays.
    `FPRT_ASSERT(a_single_toggle, i_clk, i_rst_n, ($past(i_rst_n) && (o_relay_one_level != $past(o_relay_one_level))) |-> (o_relay_two_level == $past(o_relay_two_level)), "both relays changed in one word")

    // A stalled result word stays and holds its fields.
    `FPRT_ASSERT(a_stall_hold, i_clk, i_rst_n, ($past(i_rst_n) && $past(o_valid && i_stall)) |-> (o_valid && $stable(o_relay_one_level) && $stable(o_relay_two_level) && $stable(o_frame_accepted) && $stable(o_frame_dropped)), "stalled result word changed")

    // The configuration port never inserts wait states.
    `FPRT_ASSERT_ALWAYS(a_pready_high, i_clk, !i_rst_n || pready, "pready dropped")

endmodule

bind framed_packet_relay_toggler fprt_port_check u_port_check (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_relay_one_level (o_relay_one_level),
    .o_relay_two_level (o_relay_two_level),
    .o_frame_accepted  (o_frame_accepted),
    .o_frame_dropped   (o_frame_dropped),
    .pready            (pready)
);
